// ----- design/per_file_lfu_cluster_cache_assert.svh -----
// ----------------------------------------------------------------------------
// per-file lfu cluster cache assertion macros
// immediate-implication and next-cycle checks on aclk, off during reset
// ----------------------------------------------------------------------------
`ifndef PER_FILE_LFU_CLUSTER_CACHE_ASSERT_SVH
`define PER_FILE_LFU_CLUSTER_CACHE_ASSERT_SVH

// same-cycle implication
`define PFLC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pflc check failed");

// next-cycle implication
`define PFLC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pflc check failed");

`endif

// ----- design/pflc_pkg.sv -----
// ----------------------------------------------------------------------------
// pflc_pkg
// shared sizes, codes, types and helpers of the per-file lfu cluster cache
// ----------------------------------------------------------------------------
package pflc_pkg;

    localparam int FILE_SETS   = 16;
    localparam int MAX_SLOTS   = 8;
    localparam int COUNT_WIDTH = 24;

    localparam int TAG_W      = 32;
    localparam int FIDX_W     = 4;
    localparam int BPF_W      = 4;
    localparam int OUT_SLOT_W = 3;
    localparam int FILE_W     = (FILE_SETS > 1) ? $clog2(FILE_SETS) : 1;
    localparam int SLOT_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int ACT_W      = $clog2(MAX_SLOTS + 1);
    localparam int ENTRY_W    = TAG_W + COUNT_WIDTH;
    localparam int ROW_W      = MAX_SLOTS * ENTRY_W;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 40;
    localparam int M_USED_W   = 1 + OUT_SLOT_W + 1 + 1 + TAG_W;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [BPF_W-1:0]       BPF_RESET = BPF_W'(8);

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic REG_BPF = 1'b0;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] hit_slot;
        logic              free_found;
        logic [SLOT_W-1:0] free_slot;
        logic [SLOT_W-1:0] victim_slot;
    } sel_t;

    function automatic logic [FILE_W-1:0] file_wrap(input logic [FIDX_W-1:0] f);
        logic [FILE_W-1:0] r;
        r = '0;
        for (int k = 0; k < (1 << FIDX_W); k++) begin
            if (f == FIDX_W'(k)) r = FILE_W'(k % FILE_SETS);
        end
        return r;
    endfunction

    function automatic logic [ACT_W-1:0] active_count(input logic [BPF_W-1:0] bpf);
        logic [ACT_W-1:0] r;
        if (bpf == '0) r = ACT_W'(1);
        else if (int'(bpf) > MAX_SLOTS) r = ACT_W'(MAX_SLOTS);
        else r = ACT_W'(bpf);
        return r;
    endfunction

    function automatic logic [OUT_SLOT_W-1:0] slot_out(input logic [SLOT_W-1:0] s);
        logic [SLOT_W+OUT_SLOT_W-1:0] t;
        t = (SLOT_W + OUT_SLOT_W)'(s);
        return t[OUT_SLOT_W-1:0];
    endfunction

endpackage

// ----- design/per_file_lfu_cluster_cache.sv -----
// ----------------------------------------------------------------------------
// per_file_lfu_cluster_cache
// lfu tag and replacement engine for per-file sets of cached disk clusters
// ----------------------------------------------------------------------------
//  port group   dir   contents
//  s_*          in    lookup or write request: tuser command, tdata file and cluster
//  m_*          out   one result per request: hit, slot, eviction
//  apb          in    blocks_per_file register at address 0
//
//  a request reads the set row from the tag ram on acceptance, then does compare,
//  victim search and write-back of the row in the look state
//  the look state waits while a previous result is still held on m_*
//  valid bits sit in flops cleared by reset, so no clearing pass is needed
//  reset is synchronous, active low on aresetn
// ----------------------------------------------------------------------------
`include "per_file_lfu_cluster_cache_assert.svh"

module per_file_lfu_cluster_cache (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pflc_pkg::S_DATA_W-1:0] s_tdata,  // file_index, cluster_number, zero pad
    input  logic                          s_tuser,  // command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pflc_pkg::M_DATA_W-1:0] m_tdata,  // hit, slot, slot_valid, evicted,
                                                    // evicted_cluster, zero pad
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    typedef enum logic {
        ST_IDLE,
        ST_LOOK
    } state_t;

    state_t                         state_reg;
    logic                           m_tvalid_reg;
    logic [pflc_pkg::M_DATA_W-1:0]  m_tdata_reg;
    logic [pflc_pkg::M_DATA_W-1:0]  m_tdata_next;
    logic [pflc_pkg::BPF_W-1:0]     bpf_reg;
    logic                           cmd_reg;
    logic [pflc_pkg::FILE_W-1:0]    file_reg;
    logic [pflc_pkg::TAG_W-1:0]     tag_reg;
    logic [pflc_pkg::MAX_SLOTS-1:0] valid_reg [pflc_pkg::FILE_SETS];
    logic [pflc_pkg::MAX_SLOTS-1:0] valid_next;

    logic                           in_acc;
    logic                           go;
    logic                           ram_we;
    logic [pflc_pkg::ROW_W-1:0]     ram_rdata;
    logic [pflc_pkg::ROW_W-1:0]     row_next;
    logic [pflc_pkg::ACT_W-1:0]     active;
    pflc_pkg::sel_t                 sel;
    logic [pflc_pkg::SLOT_W-1:0]    target;
    logic                           res_valid;
    logic                           res_evict;
    logic [pflc_pkg::TAG_W-1:0]     ev_cluster;
    logic [pflc_pkg::COUNT_WIDTH-1:0] cnt;

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr[2] == pflc_pkg::REG_BPF) ? 32'(bpf_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpf_reg <= pflc_pkg::BPF_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == pflc_pkg::REG_BPF) begin
            bpf_reg <= pwdata[pflc_pkg::BPF_W-1:0];
        end
    end

    assign active = pflc_pkg::active_count(bpf_reg);

    // request capture
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign go       = (state_reg == ST_LOOK) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            cmd_reg  <= s_tuser;
            file_reg <= pflc_pkg::file_wrap(s_tdata[pflc_pkg::FIDX_W-1:0]);
            tag_reg  <= s_tdata[pflc_pkg::FIDX_W +: pflc_pkg::TAG_W];
        end
    end

    pflc_ram #(
        .WIDTH (pflc_pkg::ROW_W),
        .DEPTH (pflc_pkg::FILE_SETS)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (file_reg),
        .wdata (row_next),
        .re    (in_acc),
        .raddr (pflc_pkg::file_wrap(s_tdata[pflc_pkg::FIDX_W-1:0])),
        .rdata (ram_rdata)
    );

    pflc_sel u_sel (
        .row    (ram_rdata),
        .valid  (valid_reg[file_reg]),
        .tag    (tag_reg),
        .active (active),
        .sel    (sel)
    );

    // read-modify-write of the set row
    always_comb begin
        res_valid  = sel.hit || (cmd_reg == pflc_pkg::CMD_WRITE);
        res_evict  = !sel.hit && (cmd_reg == pflc_pkg::CMD_WRITE) && !sel.free_found;
        target     = sel.hit ? sel.hit_slot :
                     (sel.free_found ? sel.free_slot : sel.victim_slot);
        row_next   = ram_rdata;
        valid_next = valid_reg[file_reg];
        ev_cluster = '0;
        cnt        = '0;
        for (int i = 0; i < pflc_pkg::MAX_SLOTS; i++) begin
            if (pflc_pkg::SLOT_W'(i) == target) begin
                cnt = ram_rdata[i*pflc_pkg::ENTRY_W + pflc_pkg::TAG_W +: pflc_pkg::COUNT_WIDTH];
                if (res_evict) begin
                    ev_cluster = ram_rdata[i*pflc_pkg::ENTRY_W +: pflc_pkg::TAG_W];
                end
                if (sel.hit) begin
                    if (cnt != pflc_pkg::COUNT_MAX) begin
                        cnt = cnt + 1'b1;
                    end
                end else begin
                    cnt = '0;
                    row_next[i*pflc_pkg::ENTRY_W +: pflc_pkg::TAG_W] = tag_reg;
                end
                row_next[i*pflc_pkg::ENTRY_W + pflc_pkg::TAG_W +: pflc_pkg::COUNT_WIDTH] = cnt;
                valid_next[i] = 1'b1;
            end
        end
        m_tdata_next = pflc_pkg::M_DATA_W'({ev_cluster, res_evict, res_valid,
                       (res_valid ? pflc_pkg::slot_out(target) : 3'd0), sel.hit});
    end

    assign ram_we = go && res_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int f = 0; f < pflc_pkg::FILE_SETS; f++) begin
                valid_reg[f] <= '0;
            end
        end else if (ram_we) begin
            valid_reg[file_reg] <= valid_next;
        end
    end

    // control and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (go) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= m_tdata_next;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    if (go) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `PFLC_ASSERT_NEXT(a_one_at_a_time, in_acc, !s_tready)
    `PFLC_ASSERT_NOW(a_evict_is_write_miss, m_tvalid && m_tdata[5], !m_tdata[0] && m_tdata[4])
    `PFLC_ASSERT_NEXT(a_writeback_ends_request, ram_we, s_tready && m_tvalid)

endmodule

// ----- design/pflc_ram.sv -----
// ----------------------------------------------------------------------------
// pflc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module pflc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/pflc_sel.sv -----
// ----------------------------------------------------------------------------
// pflc_sel
// tag compare, lowest free slot and least-used victim over one set row
// ----------------------------------------------------------------------------
module pflc_sel (
    input  logic [pflc_pkg::ROW_W-1:0]     row,
    input  logic [pflc_pkg::MAX_SLOTS-1:0] valid,
    input  logic [pflc_pkg::TAG_W-1:0]     tag,
    input  logic [pflc_pkg::ACT_W-1:0]     active,
    output pflc_pkg::sel_t                 sel
);

    logic [pflc_pkg::TAG_W-1:0]       tags   [pflc_pkg::MAX_SLOTS];
    logic [pflc_pkg::COUNT_WIDTH-1:0] counts [pflc_pkg::MAX_SLOTS];
    logic [pflc_pkg::COUNT_WIDTH-1:0] min_count;

    always_comb begin
        for (int i = 0; i < pflc_pkg::MAX_SLOTS; i++) begin
            tags[i]   = row[i*pflc_pkg::ENTRY_W +: pflc_pkg::TAG_W];
            counts[i] = row[i*pflc_pkg::ENTRY_W + pflc_pkg::TAG_W +: pflc_pkg::COUNT_WIDTH];
        end
    end

    always_comb begin
        sel       = '0;
        min_count = counts[0];
        for (int i = pflc_pkg::MAX_SLOTS - 1; i >= 0; i--) begin
            if (pflc_pkg::ACT_W'(i) < active) begin
                if (valid[i] && tags[i] == tag) begin
                    sel.hit      = 1'b1;
                    sel.hit_slot = pflc_pkg::SLOT_W'(i);
                end
                if (!valid[i]) begin
                    sel.free_found = 1'b1;
                    sel.free_slot  = pflc_pkg::SLOT_W'(i);
                end
            end
        end
        // strict less keeps the lowest slot on ties
        for (int i = 1; i < pflc_pkg::MAX_SLOTS; i++) begin
            if (pflc_pkg::ACT_W'(i) < active && counts[i] < min_count) begin
                min_count       = counts[i];
                sel.victim_slot = pflc_pkg::SLOT_W'(i);
            end
        end
    end

endmodule

// ----- verif/per_file_lfu_cluster_cache_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// per_file_lfu_cluster_cache_tb
// drives lookup and write requests on the s_ stream and slot count settings
// over apb, predicts hit, slot and eviction of every request from a copy of
// the per-file lfu sets, and checks each m_ result in order
// ----------------------------------------------------------------------------
module per_file_lfu_cluster_cache_tb;

    localparam int LIMIT_CYCLES = 300000;

    typedef struct packed {
        logic [pflc_pkg::TAG_W-1:0]      evicted_cluster;
        logic                            evicted;
        logic                            slot_valid;
        logic [pflc_pkg::OUT_SLOT_W-1:0] slot;
        logic                            hit;
    } cache_result_t;

    class lfu_cache_checker;
        bit                             set_valid [pflc_pkg::FILE_SETS][pflc_pkg::MAX_SLOTS];
        bit [pflc_pkg::TAG_W-1:0]       set_tag   [pflc_pkg::FILE_SETS][pflc_pkg::MAX_SLOTS];
        bit [pflc_pkg::COUNT_WIDTH-1:0] set_uses  [pflc_pkg::FILE_SETS][pflc_pkg::MAX_SLOTS];
        bit [pflc_pkg::BPF_W-1:0]       slot_cfg;
        cache_result_t                  expected_results[$];
        int                             errors;

        function new();
            slot_cfg = pflc_pkg::BPF_RESET;
            errors = 0;
            foreach (set_valid[f, s]) set_valid[f][s] = 1'b0;
        endfunction

        function void note_request(logic cmd, logic [pflc_pkg::FIDX_W-1:0] fidx,
                                   logic [pflc_pkg::TAG_W-1:0] cluster);
            int active, file, found, free_idx, victim;
            cache_result_t r;
            active = (slot_cfg == 0) ? 1 :
                     ((slot_cfg > pflc_pkg::MAX_SLOTS) ? pflc_pkg::MAX_SLOTS : slot_cfg);
            file = fidx % pflc_pkg::FILE_SETS;
            found = -1;
            free_idx = -1;
            r = '0;
            for (int i = 0; i < active; i++) begin
                if (set_valid[file][i]) begin
                    if (found < 0 && set_tag[file][i] == cluster) found = i;
                end else if (free_idx < 0) begin
                    free_idx = i;
                end
            end
            if (found >= 0) begin
                if (set_uses[file][found] != pflc_pkg::COUNT_MAX) set_uses[file][found]++;
                r.hit = 1'b1;
                r.slot = pflc_pkg::OUT_SLOT_W'(found);
                r.slot_valid = 1'b1;
            end else if (cmd == pflc_pkg::CMD_WRITE) begin
                if (free_idx >= 0) begin
                    victim = free_idx;
                end else begin
                    victim = 0;
                    for (int i = 1; i < active; i++) begin
                        if (set_uses[file][i] < set_uses[file][victim]) victim = i;
                    end
                    r.evicted = 1'b1;
                    r.evicted_cluster = set_tag[file][victim];
                end
                set_valid[file][victim] = 1'b1;
                set_tag[file][victim] = cluster;
                set_uses[file][victim] = '0;
                r.slot = pflc_pkg::OUT_SLOT_W'(victim);
                r.slot_valid = 1'b1;
            end
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [pflc_pkg::TAG_W-1:0] want,
                                    logic [pflc_pkg::TAG_W-1:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [pflc_pkg::M_DATA_W-1:0] data);
            cache_result_t got, want;
            got = data[pflc_pkg::M_USED_W-1:0];
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("hit", want.hit, got.hit);
            compare_field("slot", want.slot, got.slot);
            compare_field("slot_valid", want.slot_valid, got.slot_valid);
            compare_field("evicted", want.evicted, got.evicted);
            compare_field("evicted_cluster", want.evicted_cluster, got.evicted_cluster);
        endfunction
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [pflc_pkg::S_DATA_W-1:0] s_tdata;
    logic                          s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [pflc_pkg::M_DATA_W-1:0] m_tdata;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [2:0]                    paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    lfu_cache_checker           sb;
    int                         send_gap_max;
    int                         recv_gap_max;
    bit                         s_holding;
    int                         cycle_count;
    logic [pflc_pkg::TAG_W-1:0] cluster_pool [10];

    per_file_lfu_cluster_cache u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_request(logic cmd, logic [pflc_pkg::FIDX_W-1:0] fidx,
                                logic [pflc_pkg::TAG_W-1:0] cluster);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= pflc_pkg::S_DATA_W'({cluster, fidx});
        do @(posedge aclk); while (!s_tready);
        sb.note_request(cmd, fidx, cluster);
        gap = $urandom_range(0, send_gap_max);
        s_holding = (gap == 0);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // drop valid and let every outstanding request finish
    task automatic wait_idle();
        if (s_holding) begin
            s_tvalid <= 1'b0;
            s_holding = 1'b0;
        end
        do @(posedge aclk); while (sb.expected_results.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_slot_count(logic [pflc_pkg::BPF_W-1:0] value);
        wait_idle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(4 * pflc_pkg::REG_BPF);
        pwdata <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.slot_cfg = value;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== 32'(value)) begin
            $display("%0t: blocks_per_file readback mismatch, expected %h actual %h",
                     $time, 32'(value), prdata);
            sb.errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_phase(logic [pflc_pkg::BPF_W-1:0] bpf, int count, bit drain_midway);
        logic                       cmd;
        logic [3:0]                 fidx;
        logic [pflc_pkg::TAG_W-1:0] cluster;
        int                         pick;
        bit                         narrow;
        set_slot_count(bpf);
        send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
        recv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
        narrow = ($urandom_range(0, 3) != 0);
        foreach (cluster_pool[k]) begin
            cluster_pool[k] = ($urandom_range(0, 1) == 0)
                              ? pflc_pkg::TAG_W'($urandom_range(0, 63))
                              : pflc_pkg::TAG_W'($urandom);
        end
        for (int n = 0; n < count; n++) begin
            if (drain_midway && n == count / 2) wait_idle();
            cmd = ($urandom_range(0, 9) < 6) ? pflc_pkg::CMD_WRITE : pflc_pkg::CMD_READ;
            fidx = narrow ? 4'($urandom_range(0, 2)) : 4'($urandom_range(0, 15));
            pick = $urandom_range(0, 9);
            if (pick < 7) cluster = cluster_pool[$urandom_range(0, 9)];
            else if (pick == 7) cluster = $urandom_range(0, 1) ? '1 : '0;
            else cluster = pflc_pkg::TAG_W'($urandom);
            send_request(cmd, fidx, cluster);
        end
    endtask

    initial begin
        int gap;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            gap = $urandom_range(0, recv_gap_max);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata);
        end
    end

    initial begin
        logic [pflc_pkg::BPF_W-1:0] phase_cfg [14];
        sb = new();
        phase_cfg = '{4'd1, 4'd8, 4'd3, 4'd0, 4'd15, 4'd5, 4'd2, 4'd7,
                      4'd4, 4'd6, 4'd9, 4'd8, 4'd12, 4'd10};
        cycle_count <= 0;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= pflc_pkg::CMD_READ;
        m_tready <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        s_holding = 1'b0;
        send_gap_max = 6;
        recv_gap_max = 6;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty sets, fills, hits, read miss, evictions with lfu choice
        send_request(pflc_pkg::CMD_WRITE, 4'd0, 32'h0000_0000);
        send_request(pflc_pkg::CMD_WRITE, 4'd15, 32'hFFFF_FFFF);
        send_request(pflc_pkg::CMD_READ, 4'd0, 32'h0000_0000);
        send_request(pflc_pkg::CMD_READ, 4'd15, 32'hFFFF_FFFF);
        send_request(pflc_pkg::CMD_READ, 4'd15, 32'h1234_5678);
        send_request(pflc_pkg::CMD_WRITE, 4'd0, 32'h0000_0000);
        for (int k = 1; k < 8; k++) begin
            send_request(pflc_pkg::CMD_WRITE, 4'd0, pflc_pkg::TAG_W'(k));
        end
        send_request(pflc_pkg::CMD_READ, 4'd0, 32'd5);
        send_request(pflc_pkg::CMD_WRITE, 4'd0, 32'd100);
        send_request(pflc_pkg::CMD_WRITE, 4'd0, 32'd200);
        // slots above the active count are skipped but kept
        set_slot_count(4'd2);
        send_request(pflc_pkg::CMD_WRITE, 4'd0, 32'd300);
        send_request(pflc_pkg::CMD_READ, 4'd0, 32'd7);
        set_slot_count(4'd0);
        send_request(pflc_pkg::CMD_WRITE, 4'd0, 32'd400);
        send_request(pflc_pkg::CMD_READ, 4'd0, 32'd400);
        set_slot_count(4'd15);
        send_request(pflc_pkg::CMD_READ, 4'd0, 32'd7);
        send_request(pflc_pkg::CMD_WRITE, 4'd0, 32'hA5A5_5A5A);

        foreach (phase_cfg[p]) run_phase(phase_cfg[p], 88, (p == 2) || (p == 9));

        wait_idle();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
